### hw/rtl/vcs_pkg.sv
// Package for the one-wire voice-chip command sender.
// Holds shared types, function/op codes and frame constants; no dependencies.
package vcs_pkg;

  localparam int BITS_PER_FRAME = 8;
  localparam int BIT_CNT_W = (BITS_PER_FRAME > 1) ? $clog2(BITS_PER_FRAME) : 1;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_FRAME - 1);

  localparam int TICK_W  = 16;
  localparam int CODE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // input function codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_PLAY = 2'd1;
  localparam logic [1:0] FUNC_VOL  = 2'd2;

  // command code bases
  localparam logic [CODE_W-1:0] CODE_PLAY_BASE = 8'h00;
  localparam logic [CODE_W-1:0] CODE_VOL_BASE  = 8'hE0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PLAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOL     = 3'd4;

  // register reset values
  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd600;
  localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd200;
  localparam logic [TICK_W-1:0] START_TICKS_RST = 16'd5000;
  localparam logic [7:0]        MAX_PLAY_RST    = 8'd223;
  localparam logic [3:0]        MAX_VOL_RST     = 4'd15;

  typedef struct packed {
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] start_ticks;
    logic [7:0]        max_play_index;
    logic [3:0]        max_volume;
  } cfg_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_CMD  = 2'd1,
    OP_NOP  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
  } q_item_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_HIGH  = 4'b0100,
    PH_LOW   = 4'b1000
  } phase_t;

endpackage

### hw/rtl/vcs_if.sv
// Valid/ready channel interfaces for the command sender.
// Depends on nothing; payload widths match the package field widths.
interface vcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface vcs_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic command_dropped;

  modport source (output valid, output line_level, output busy_res,
                  output command_dropped, input ready);
  modport sink   (input valid, input line_level, input busy_res,
                  input command_dropped, output ready);
endinterface

### hw/rtl/voice_chip_one_wire_sender_unit.sv
// One-wire pulse-width command sender for a voice-playback chip. Each input
// transfer is a tick (func 0), a play command (func 1) or a volume command
// (func 2); every transfer yields exactly one result transfer carrying the
// wire level, the busy flag and a dropped flag for commands that arrive while
// a frame is still going out. A frame is a start low of start_ticks, then
// eight bits LSB first, each a high half and a low half whose lengths are
// long_ticks/short_ticks (one) or short_ticks/long_ticks (zero). Throughput is
// one transfer per clock while neither channel stalls; each result is
// registered behind the two-entry queue register and the result register. Both
// channels may stall independently: the queue absorbs up to two items while the
// result waits. Write configuration only while the block is idle.
// Depends on vcs_pkg, vcs_if, vcs_front, vcs_queue and vcs_back.
module voice_chip_one_wire_sender_unit
  import vcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  vcs_in_if.sink               in_ch,
  vcs_out_if.source            out_ch
);

  cfg_t    cfg_r;
  logic    q_full;
  logic    q_push;
  q_item_t q_push_item;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_head;

  // configuration registers, write-only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks     <= LONG_TICKS_RST;
      cfg_r.short_ticks    <= SHORT_TICKS_RST;
      cfg_r.start_ticks    <= START_TICKS_RST;
      cfg_r.max_play_index <= MAX_PLAY_RST;
      cfg_r.max_volume     <= MAX_VOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LONG_TICKS:  cfg_r.long_ticks     <= cfg_wdata;
        REG_SHORT_TICKS: cfg_r.short_ticks    <= cfg_wdata;
        REG_START_TICKS: cfg_r.start_ticks    <= cfg_wdata;
        REG_MAX_PLAY:    cfg_r.max_play_index <= cfg_wdata[7:0];
        REG_MAX_VOL:     cfg_r.max_volume     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // decode and clamp
  vcs_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_push_item)
  );

  // decouple front from back
  vcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  // frame sequencer and result register
  vcs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### hw/rtl/vcs_front.sv
// Front end: accepts input transfers, decodes func and clamps command values.
// Depends on vcs_pkg and vcs_in_if.
module vcs_front
  import vcs_pkg::*;
(
  vcs_in_if.sink   in_ch,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output q_item_t  q_item
);

  logic [7:0] play_idx;
  logic [3:0] vol_lvl;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // clamp to the configured limits
  assign play_idx = (in_ch.value > cfg.max_play_index) ? cfg.max_play_index : in_ch.value;
  assign vol_lvl  = (in_ch.value > {4'b0, cfg.max_volume}) ? cfg.max_volume
                                                          : in_ch.value[3:0];

  always_comb begin
    q_item.op   = OP_NOP;
    q_item.code = '0;
    unique case (in_ch.func)
      FUNC_TICK: begin
        q_item.op = OP_TICK;
      end
      FUNC_PLAY: begin
        q_item.op   = OP_CMD;
        q_item.code = CODE_PLAY_BASE + play_idx;
      end
      FUNC_VOL: begin
        q_item.op   = OP_CMD;
        q_item.code = CODE_VOL_BASE + {4'b0, vol_lvl};
      end
      default: begin
        q_item.op = OP_NOP;
      end
    endcase
  end

endmodule

### hw/rtl/vcs_queue.sv
// Two-entry queue between front end and back end.
// Depends on vcs_pkg for the entry type.
module vcs_queue
  import vcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output logic    full,
  output logic    head_valid,
  output q_item_t head_item
);

  q_item_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/vcs_back.sv
// Back end: frame sequencer driving the wire level, plus the result register.
// Depends on vcs_pkg and vcs_out_if.
module vcs_back
  import vcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  vcs_out_if.source out_ch
);

  phase_t                phase_r, phase_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [CODE_W-1:0]     shift_r, shift_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic                  line_r, line_nxt;
  logic                  drop;

  logic                  out_valid_r;
  logic                  out_line_r, out_busy_r, out_drop_r;

  logic [TICK_W-1:0]     dur;
  logic [TICK_W:0]       tick_inc;
  logic                  done;
  logic                  fire;

  assign fire  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = fire;

  // duration of the running period; a zero register acts as one tick
  always_comb begin
    unique case (phase_r)
      PH_START: dur = cfg.start_ticks;
      PH_HIGH:  dur = shift_r[0] ? cfg.long_ticks  : cfg.short_ticks;
      PH_LOW:   dur = shift_r[0] ? cfg.short_ticks : cfg.long_ticks;
      default:  dur = cfg.start_ticks;
    endcase
  end

  assign tick_inc = {1'b0, tick_r} + {{TICK_W{1'b0}}, 1'b1};
  assign done     = (tick_inc >= {1'b0, dur});

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    line_nxt    = line_r;
    drop        = 1'b0;
    unique case (q_item.op)
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          tick_nxt = done ? '0 : tick_inc[TICK_W-1:0];
        end
        unique case (phase_r)
          PH_START: begin
            if (done) begin
              phase_nxt = PH_HIGH;
              line_nxt  = 1'b1;
            end
          end
          PH_HIGH: begin
            if (done) begin
              phase_nxt = PH_LOW;
              line_nxt  = 1'b0;
            end
          end
          PH_LOW: begin
            if (done) begin
              shift_nxt = {1'b0, shift_r[CODE_W-1:1]};
              line_nxt  = 1'b1;
              if (bit_cnt_r >= LAST_BIT) begin
                phase_nxt   = PH_IDLE;
                bit_cnt_nxt = '0;
              end else begin
                bit_cnt_nxt = bit_cnt_r + 1'b1;
                phase_nxt   = PH_HIGH;
              end
            end
          end
          default: ;
        endcase
      end
      OP_CMD: begin
        if (phase_r != PH_IDLE) begin
          drop = 1'b1;
        end else begin
          // line drops at once: start of the start-low period
          shift_nxt   = q_item.code;
          bit_cnt_nxt = '0;
          tick_nxt    = '0;
          phase_nxt   = PH_START;
          line_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      line_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        tick_r    <= tick_nxt;
        line_r    <= line_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_line_r <= line_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_drop_r <= drop;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.line_level      = out_line_r;
  assign out_ch.busy_res        = out_busy_r;
  assign out_ch.command_dropped = out_drop_r;

endmodule

### hw/rtl/vcs_checker.sv
// Port-level checks for the command sender, bound to the top level.
// Depends only on the top-level ports.
module vcs_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic line_level,
  input logic busy_res,
  input logic command_dropped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(line_level) && $stable(busy_res)
      && $stable(command_dropped))
    else $error("result changed while stalled");

  // a drop only happens while a frame is going out
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && command_dropped |-> busy_res)
    else $error("command dropped while idle");

  // idle line is high
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> line_level)
    else $error("line low while idle");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind voice_chip_one_wire_sender_unit vcs_checker u_vcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .line_level      (out_ch.line_level),
  .busy_res        (out_ch.busy_res),
  .command_dropped (out_ch.command_dropped)
);
